// File: hw/rtl/tmm_pkg.sv
// shared types and constants for the tile matrix multiply block
package tmm_pkg;

  localparam int TILE_WORDS = 8192;
  localparam int ADDR_W     = $clog2(TILE_WORDS);
  localparam int IDX_W      = 13;
  localparam int DIM_W      = 14;
  localparam int DATA_W     = 32;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int BASE_W     = IDX_W + DIM_W;

  // request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_BT = 2'd1,
    CMD_COMPUTE = 2'd2
  } tmm_cmd_t;

  localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_B_COLS    = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] inner_len;
    logic [DIM_W-1:0] b_cols;
  } tmm_cfg_t;

  typedef struct packed {
    tmm_cmd_t          cmd;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
  } tmm_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] dot_value;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              status;
  } tmm_result_t;

endpackage

// File: hw/rtl/tmm_ram.sv
// generic simple dual-port ram with registered read
module tmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/tmm_front.sv
// front end: accepts requests, drops meaningless ones, queues the rest
module tmm_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                command,
  input  logic [12:0]               elem_index,
  input  logic signed [31:0]        elem_value,
  input  logic [12:0]               res_row,
  input  logic [12:0]               res_col,
  output logic                      q_valid,
  output tmm_pkg::tmm_item_t        q_item,
  input  logic                      q_pop
);
  import tmm_pkg::*;

  tmm_item_t           entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                keep;
  logic                wr_en;
  logic                rd_en;
  tmm_item_t           new_item;

  // loads past the store and unknown commands vanish here
  always_comb begin
    unique case (command)
      CMD_LOAD_A, CMD_LOAD_BT: keep = (32'(elem_index) < TILE_WORDS);
      CMD_COMPUTE:             keep = 1'b1;
      default:                 keep = 1'b0;
    endcase
  end

  always_comb begin
    new_item.cmd   = tmm_cmd_t'(command);
    new_item.idx   = elem_index;
    new_item.value = elem_value;
    new_item.row   = res_row;
    new_item.col   = res_col;
  end

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign wr_en   = push && !full && keep;
  assign rd_en   = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/tmm_back.sv
// back end: element stores, range check and multiply-accumulate sequencer
module tmm_back (
  input  logic                  clk,
  input  logic                  rst,
  input  tmm_pkg::tmm_cfg_t     cfg,
  input  logic                  q_valid,
  input  tmm_pkg::tmm_item_t    q_item,
  output logic                  q_pop,
  input  logic                  out_pop,
  output logic                  res_valid,
  output tmm_pkg::tmm_result_t  res
);
  import tmm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_CHECK,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   cur_row;
  logic [IDX_W-1:0]   cur_col;
  logic [BASE_W-1:0]  abase;
  logic [BASE_W-1:0]  bbase;
  logic [DIM_W-1:0]   j;
  logic               status_r;
  logic               rd_valid;
  logic               prod_valid;
  logic [DATA_W-1:0]  prod;
  logic [DATA_W-1:0]  acc;

  logic               we_a;
  logic               we_b;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr_a;
  logic [ADDR_W-1:0]  raddr_b;
  logic [DATA_W-1:0]  a_rdata;
  logic [DATA_W-1:0]  b_rdata;
  logic [BASE_W:0]    a_end;
  logic [BASE_W:0]    b_end;
  logic               fail;
  logic               res_load;

  always_comb begin
    q_pop    = (state == S_IDLE) && q_valid;
    we_a     = q_pop && (q_item.cmd == CMD_LOAD_A);
    we_b     = q_pop && (q_item.cmd == CMD_LOAD_BT);
    waddr    = q_item.idx[ADDR_W-1:0];
    raddr_a  = ADDR_W'(abase[ADDR_W-1:0] + j[ADDR_W-1:0]);
    raddr_b  = ADDR_W'(bbase[ADDR_W-1:0] + j[ADDR_W-1:0]);
    // finished result moves into the output register once it is free
    res_load = (state == S_DONE) && (!res_valid || out_pop);
  end

  // row or column outside the tile, or its row runs off the store
  always_comb begin
    a_end = {1'b0, abase} + (BASE_W+1)'(cfg.inner_len);
    b_end = {1'b0, bbase} + (BASE_W+1)'(cfg.inner_len);
    fail  = ({1'b0, cur_row} >= cfg.a_rows) || ({1'b0, cur_col} >= cfg.b_cols)
         || (a_end > (BASE_W+1)'(TILE_WORDS)) || (b_end > (BASE_W+1)'(TILE_WORDS));
  end

  tmm_ram #(.WIDTH(DATA_W), .DEPTH(TILE_WORDS)) u_a_ram (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (q_item.value),
    .raddr (raddr_a),
    .rdata (a_rdata)
  );

  tmm_ram #(.WIDTH(DATA_W), .DEPTH(TILE_WORDS)) u_bt_ram (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (q_item.value),
    .raddr (raddr_b),
    .rdata (b_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      rd_valid   <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      rd_valid   <= (state == S_RUN);
      prod_valid <= rd_valid;
      prod       <= DATA_W'(a_rdata * b_rdata);
      if (prod_valid) begin
        acc <= acc + prod;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && (q_item.cmd == CMD_COMPUTE)) begin
            cur_row <= q_item.row;
            cur_col <= q_item.col;
            state   <= S_BASE;
          end
        end
        S_BASE: begin
          abase <= {{DIM_W{1'b0}}, cur_row} * {{IDX_W{1'b0}}, cfg.inner_len};
          bbase <= {{DIM_W{1'b0}}, cur_col} * {{IDX_W{1'b0}}, cfg.inner_len};
          acc   <= '0;
          j     <= '0;
          state <= S_CHECK;
        end
        S_CHECK: begin
          status_r <= fail ? STATUS_RANGE : STATUS_OK;
          if (fail || (cfg.inner_len == '0)) begin
            state <= S_DONE;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          j <= j + 1'b1;
          if (j == DIM_W'(cfg.inner_len - 1'b1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_valid && !prod_valid) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            res.dot_value <= acc;
            res.row       <= cur_row;
            res.col       <= cur_col;
            res.status    <= status_r;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/tile_matrix_multiply.sv
// top level of the tile matrix multiply block
// loads: written in the back end while it is idle, queued behind a four-deep request queue
// compute: one multiply-accumulate issue per cycle plus base, check, drain and result steps;
//   the next request is taken only once the result has moved to the output register
// an out-of-range or zero-length compute skips the run and drain steps
// reset clears the request queue, result register and sequencer; registers return to 1, stores stay
module tile_matrix_multiply (
  input  logic                clk,
  input  logic                rst,
  // request side
  input  logic                push,
  output logic                full,
  input  logic [1:0]          command,
  input  logic [12:0]         elem_index,
  input  logic signed [31:0]  elem_value,
  input  logic [12:0]         res_row,
  input  logic [12:0]         res_col,
  // result side
  output logic                empty,
  input  logic                pop,
  output logic signed [31:0]  dot_value,
  output logic [12:0]         out_row,
  output logic [12:0]         out_col,
  output logic                status,
  // register write port
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [13:0]         cfg_data
);
  import tmm_pkg::*;

  tmm_cfg_t     cfg;
  logic         q_valid;
  tmm_item_t    q_item;
  logic         q_pop;
  logic         res_valid;
  tmm_result_t  res;
  logic         out_pop;

  // register writes always land at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.a_rows    <= DIM_W'(1);
      cfg.inner_len <= DIM_W'(1);
      cfg.b_cols    <= DIM_W'(1);
    end else if (cfg_valid) begin
      // an index past the list is ignored
      unique case (cfg_index)
        CFG_A_ROWS:    cfg.a_rows    <= cfg_data;
        CFG_INNER_LEN: cfg.inner_len <= cfg_data;
        CFG_B_COLS:    cfg.b_cols    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // front: classify and queue requests
  tmm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .command    (command),
    .elem_index (elem_index),
    .elem_value (elem_value),
    .res_row    (res_row),
    .res_col    (res_col),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // back: stores and dot product sequencer, holds one finished result
  tmm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_pop   = pop && res_valid;
  assign empty     = !res_valid;
  assign dot_value = res.dot_value;
  assign out_row   = res.row;
  assign out_col   = res.col;
  assign status    = res.status;

endmodule

// File: hw/rtl/tmm_checker.sv
// port-level checks for the tile matrix multiply block, bound to the top level
module tmm_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input logic signed [31:0]  dot_value,
  input logic [12:0]         out_row,
  input logic [12:0]         out_col,
  input logic                status,
  input logic                cfg_valid,
  input logic                cfg_ready
);
  import tmm_pkg::*;

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(dot_value) && $stable(out_row)
                          && $stable(out_col) && $stable(status)))
    else $error("waiting result changed before it was taken");

  // a rejected request carries a zero value
  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status == STATUS_RANGE)) |-> (dot_value == '0))
    else $error("out of range result with nonzero value");

  // reset leaves no result and an open request side
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("reset did not clear queues");

  // register writes are never held off
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("register write held off");

  // the queue fills only behind an offered request
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> $past(push))
    else $error("queue filled without a request");

endmodule

bind tile_matrix_multiply tmm_checker u_tmm_checker (
  .clk       (clk),
  .rst       (rst),
  .push      (push),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .dot_value (dot_value),
  .out_row   (out_row),
  .out_col   (out_col),
  .status    (status),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
